### sv/single_wire_humidity_sensor_reader_core_defines.svh
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader: assertion macros
// Shared assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_CORE_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define SWHSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define SWHSR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

### sv/swhsr_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader: package
// Phase encoding, register indexes and result record.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_LOW  = 4'd1,
    PH_START_HIGH = 4'd2,
    PH_RESP_LOW   = 4'd3,
    PH_SKIP_LOW   = 4'd4,
    PH_RESP_HIGH  = 4'd5,
    PH_SKIP_HIGH  = 4'd6,
    PH_BIT_LOW    = 4'd7,
    PH_BIT_HIGH   = 4'd8,
    PH_BIT_DELAY  = 4'd9
  } phase_e;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_START_LOW    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESP_SKIP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_DELAY = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BYTE_COUNT   = 3'd4;

  localparam logic [2:0] LAST_BIT  = 3'd7;
  localparam logic [3:0] MAX_BYTES = 4'd8;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [2:0] byte_index;
    logic       read_done;
    logic       busy_res;
  } result_t;

endpackage

### sv/single_wire_humidity_sensor_reader_core.sv
// A tick request is accepted and its result sits in the output
// register on the next cycle.
// Throughput: one tick per cycle while the result channel is not stalled; the phase FSM update is a single pass.
// Reset (rst_ni low, async): phase idle, counters and shift byte cleared,
// registers back to 30000/30/80/30/5, output register empty.
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader core
// Bus master for a single-wire temperature/humidity sensor, stepped once per
// 1 us tick request carrying a start flag and the sampled line level.
// ----------------------------------------------------------------------------
`include "single_wire_humidity_sensor_reader_core_defines.svh"

module single_wire_humidity_sensor_reader_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // tick request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       start_request_i,
  input  logic       bus_level_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       drive_enable_o,
  output logic       drive_level_o,
  output logic       byte_valid_o,
  output logic [7:0] byte_value_o,
  output logic [2:0] byte_index_o,
  output logic       read_done_o,
  output logic       busy_res_o,
  // register write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] start_low_q;
  logic [7:0]  release_high_q;
  logic [7:0]  resp_skip_q;
  logic [7:0]  sample_delay_q;
  logic [3:0]  byte_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q    <= 16'd30000;
      release_high_q <= 8'd30;
      resp_skip_q    <= 8'd80;
      sample_delay_q <= 8'd30;
      byte_count_q   <= 4'd5;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        swhsr_pkg::CFG_START_LOW:    start_low_q    <= cfg_data_i;
        swhsr_pkg::CFG_RELEASE_HIGH: release_high_q <= cfg_data_i[7:0];
        swhsr_pkg::CFG_RESP_SKIP:    resp_skip_q    <= cfg_data_i[7:0];
        swhsr_pkg::CFG_SAMPLE_DELAY: sample_delay_q <= cfg_data_i[7:0];
        swhsr_pkg::CFG_BYTE_COUNT:   byte_count_q   <= cfg_data_i[3:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Bytes per read, clamped to 1..8.
  logic [3:0] bytes_per_read;
  always_comb begin
    if (byte_count_q == 4'd0) begin
      bytes_per_read = 4'd1;
    end else if (byte_count_q > swhsr_pkg::MAX_BYTES) begin
      bytes_per_read = swhsr_pkg::MAX_BYTES;
    end else begin
      bytes_per_read = byte_count_q;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the output register frees up when it is empty or being taken,
  // so a stalled result only blocks the next tick, never the current one.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Phase FSM state
  // --------------------------------------------------------------------------
  swhsr_pkg::phase_e phase_q, phase_d;
  logic [15:0] timer_q, timer_d;
  logic [2:0]  bit_pos_q, bit_pos_d;
  logic [2:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  shift_q, shift_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= swhsr_pkg::PH_IDLE;
      timer_q    <= 16'd0;
      bit_pos_q  <= 3'd0;
      byte_pos_q <= 3'd0;
      shift_q    <= 8'd0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      bit_pos_q  <= bit_pos_d;
      byte_pos_q <= byte_pos_d;
      shift_q    <= shift_d;
    end
  end

  // One shared timer compare: the limit is picked by the current phase.
  // A timed phase of N ticks ends on the N-th tick after entry; zero acts
  // like one since the incremented count is compared.
  logic [15:0] timer_inc;
  logic [15:0] timer_limit;
  logic        timer_hit;
  logic [7:0]  shift_next;
  logic        last_byte;

  assign timer_inc  = timer_q + 16'd1;
  assign timer_hit  = (timer_inc >= timer_limit);
  assign shift_next = {shift_q[6:0], bus_level_i};
  assign last_byte  = ({1'b0, byte_pos_q} + 4'd1) >= bytes_per_read;

  always_comb begin
    unique case (phase_q)
      swhsr_pkg::PH_START_LOW:  timer_limit = start_low_q;
      swhsr_pkg::PH_START_HIGH: timer_limit = {8'd0, release_high_q};
      swhsr_pkg::PH_SKIP_LOW,
      swhsr_pkg::PH_SKIP_HIGH:  timer_limit = {8'd0, resp_skip_q};
      swhsr_pkg::PH_BIT_DELAY:  timer_limit = {8'd0, sample_delay_q};
      default:                  timer_limit = 16'd0;
    endcase
  end

  swhsr_pkg::result_t res_d;

  always_comb begin
    phase_d    = phase_q;
    timer_d    = timer_q;
    bit_pos_d  = bit_pos_q;
    byte_pos_d = byte_pos_q;
    shift_d    = shift_q;

    res_d            = '0;

    unique case (phase_q)
      swhsr_pkg::PH_START_LOW: begin
        timer_d = timer_inc;
        if (timer_hit) begin
          phase_d = swhsr_pkg::PH_START_HIGH;
          timer_d = 16'd0;
        end
      end
      swhsr_pkg::PH_START_HIGH: begin
        timer_d = timer_inc;
        if (timer_hit) begin
          phase_d = swhsr_pkg::PH_RESP_LOW;
          timer_d = 16'd0;
        end
      end
      swhsr_pkg::PH_RESP_LOW: begin
        if (!bus_level_i) begin
          phase_d = swhsr_pkg::PH_SKIP_LOW;
          timer_d = 16'd0;
        end
      end
      swhsr_pkg::PH_SKIP_LOW: begin
        timer_d = timer_inc;
        if (timer_hit) begin
          phase_d = swhsr_pkg::PH_RESP_HIGH;
          timer_d = 16'd0;
        end
      end
      swhsr_pkg::PH_RESP_HIGH: begin
        if (bus_level_i) begin
          phase_d = swhsr_pkg::PH_SKIP_HIGH;
          timer_d = 16'd0;
        end
      end
      swhsr_pkg::PH_SKIP_HIGH: begin
        timer_d = timer_inc;
        if (timer_hit) begin
          phase_d = swhsr_pkg::PH_BIT_LOW;
          timer_d = 16'd0;
        end
      end
      swhsr_pkg::PH_BIT_LOW: begin
        if (!bus_level_i) begin
          phase_d = swhsr_pkg::PH_BIT_HIGH;
          timer_d = 16'd0;
        end
      end
      swhsr_pkg::PH_BIT_HIGH: begin
        if (bus_level_i) begin
          phase_d = swhsr_pkg::PH_BIT_DELAY;
          timer_d = 16'd0;
        end
      end
      swhsr_pkg::PH_BIT_DELAY: begin
        timer_d = timer_inc;
        if (timer_hit) begin
          timer_d = 16'd0;
          if (bit_pos_q >= swhsr_pkg::LAST_BIT) begin
            // Byte complete: emit it, then either next byte or back to idle.
            res_d.byte_valid = 1'b1;
            res_d.byte_value = shift_next;
            res_d.byte_index = byte_pos_q;
            bit_pos_d        = 3'd0;
            shift_d          = 8'd0;
            if (last_byte) begin
              res_d.read_done = 1'b1;
              phase_d         = swhsr_pkg::PH_IDLE;
            end else begin
              byte_pos_d = byte_pos_q + 3'd1;
              phase_d    = swhsr_pkg::PH_BIT_LOW;
            end
          end else begin
            shift_d   = shift_next;
            bit_pos_d = bit_pos_q + 3'd1;
            phase_d   = swhsr_pkg::PH_BIT_LOW;
          end
        end
      end
      default: begin
        // Idle (and any stray code): wait for a start.
        phase_d = swhsr_pkg::PH_IDLE;
        if (start_request_i) begin
          bit_pos_d  = 3'd0;
          byte_pos_d = 3'd0;
          shift_d    = 8'd0;
          phase_d    = swhsr_pkg::PH_START_LOW;
          timer_d    = 16'd0;
        end
      end
    endcase

    // Line control follows the phase after this tick's update.
    unique case (phase_d)
      swhsr_pkg::PH_IDLE: begin
        res_d.drive_enable = 1'b1;
        res_d.drive_level  = 1'b1;
        res_d.busy_res     = 1'b0;
      end
      swhsr_pkg::PH_START_LOW: begin
        res_d.drive_enable = 1'b1;
        res_d.drive_level  = 1'b0;
        res_d.busy_res     = 1'b1;
      end
      swhsr_pkg::PH_START_HIGH: begin
        res_d.drive_enable = 1'b1;
        res_d.drive_level  = 1'b1;
        res_d.busy_res     = 1'b1;
      end
      default: begin
        res_d.drive_enable = 1'b0;
        res_d.drive_level  = 1'b0;
        res_d.busy_res     = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  swhsr_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_fire || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_enable_o = res_q.drive_enable;
  assign drive_level_o  = res_q.drive_level;
  assign byte_valid_o   = res_q.byte_valid;
  assign byte_value_o   = res_q.byte_value;
  assign byte_index_o   = res_q.byte_index;
  assign read_done_o    = res_q.read_done;
  assign busy_res_o     = res_q.busy_res;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SWHSR_ASSERT_IMP(a_done_has_byte, out_valid_q && res_q.read_done,
    res_q.byte_valid && !res_q.busy_res, "read_done without a final byte")
  `SWHSR_ASSERT_IMP(a_release_busy, out_valid_q && !res_q.drive_enable,
    res_q.busy_res, "line released while not busy")
  `SWHSR_ASSERT_IMP(a_stall_blocks, out_valid_q && !out_ready_i,
    !in_ready_o, "tick taken while result stalled")
  `SWHSR_ASSERT_IMP(a_idle_clean, phase_q == swhsr_pkg::PH_IDLE,
    bit_pos_q == 3'd0 && shift_q == 8'd0, "idle with partial byte")
  `SWHSR_ASSERT_IMP(a_hold_state, !$past(in_fire),
    $stable(phase_q) && $stable(timer_q), "state moved without a tick")

endmodule
